// ===== rtl/core/ism_pkg.sv =====
// ism_pkg: types and constants shared by the interval statistics monitor.
// No dependencies.
`default_nettype none
package ism_pkg;
  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_STOP   = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_REPORT = 2'd3
  } func_t;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned KEPT_W  = 5;
  localparam logic [31:0] MIN_RESET = 32'h7fff_ffff;
  localparam logic [31:0] SAT32     = 32'hffff_ffff;
  localparam logic [KEPT_W-1:0] KEPT_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  watch_id;
    logic [31:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic        misuse;
    logic [31:0] interval;
    logic [31:0] shortest;
    logic [31:0] longest;
    logic [63:0] total;
    logic [31:0] hits;
    logic [63:0] mean;
    logic [31:0] middle;
  } out_item_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/ism_if.sv =====
// ism_if: valid/ready channel carrying one transaction payload.
// Depends on ism_pkg.
`default_nettype none
interface ism_in_if import ism_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ism_out_if import ism_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ism_divider.sv =====
// ism_divider: 64-by-32 restoring divider, one quotient bit a cycle.
// Depends on ism_pkg.
`default_nettype none
module ism_divider import ism_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;
  logic [33:0] diff;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], quo_r[63]};
    diff     = {1'b0, trial} - {2'b00, dsr_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_nxt = diff[32:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

// ===== rtl/core/interval_statistics_monitor.sv =====
// interval_statistics_monitor: top level, watch state, sample memory and the
// sequencer that runs start/stop/clear/report. Depends on ism_pkg, ism_if,
// ism_divider.
//
// Usage:
//  - in: one transaction per operation (func, watch_id, stamp). out: exactly
//    one result transaction per input transaction, in order.
//  - cfg_we/cfg_wdata write samples_kept (reset 16); write only while idle.
//  - Start, stop and clear go through S_EXEC and S_OUT after acceptance
//    (update the watch, then present). The next transaction is accepted only
//    once that result has been taken by the receiver.
//  - Report runs the median selection over the k kept samples. The sample
//    memory port allows one read a cycle. Each candidate i takes one read of
//    sample i, then k reads counting the samples below it and equal to it.
//  - The serial divider for the mean runs alongside the median; a report on
//    a watch with hits waits in S_DIV_WAIT until the divider is not busy.
//  - in_ready is high only while the sequencer is idle and the output
//    register is empty; a stalled receiver holds the result and blocks the
//    next transaction.
//  - Reset initialises all watch state; sample memory is not cleared, so a
//    report after samples_kept is raised can read entries never written.
`default_nettype none
module interval_statistics_monitor import ism_pkg::*; #(
  parameter int unsigned WATCHES = 8,
  parameter int unsigned SAMPLES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ism_in_if.sink           in_ch,
  ism_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata
);
  localparam int unsigned WB  = (WATCHES > 1) ? $clog2(WATCHES) : 1;
  localparam int unsigned SB  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned KB  = $clog2(SAMPLES + 1);
  localparam int unsigned MD  = WATCHES * SAMPLES;
  localparam int unsigned MB  = (MD > 1) ? $clog2(MD) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MED_CAND, S_MED_WAIT, S_MED_SCAN, S_MED_LAST,
    S_MED_NEXT, S_DIV_WAIT, S_OUT
  } state_t;

  // watch state
  logic [WATCHES-1:0] armed_r;
  logic [31:0] start_r [WATCHES];
  logic [63:0] sum_r   [WATCHES];
  logic [31:0] max_r   [WATCHES];
  logic [31:0] min_r   [WATCHES];
  logic [31:0] hits_r  [WATCHES];
  logic [31:0] smem    [MD];
  logic [31:0] rd_r;

  logic [4:0]  kept_r;
  state_t      state_r;
  in_item_t    item_r;
  logic        oor_r;
  logic [WB-1:0] w_r;
  out_item_t   res_r;
  logic        ovalid_r;
  logic [KB-1:0] k_r, i_r, j_r, lt_r, eq_r;
  logic [31:0] cand_r, med_r;
  logic        found_r;

  // memory read address, chosen by the sequencer
  logic [MB-1:0] rd_addr;
  logic [SB-1:0] rd_idx;
  logic          rd_en;

  div_ctl_t    div;
  logic [63:0] div_q;

  ism_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div.start),
    .dividend(sum_r[w_r]), .divisor(hits_r[w_r]),
    .busy(div.busy), .done(div.done), .quotient(div_q)
  );

  assign in_ch.ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  logic [KB-1:0] kept_lim;
  logic [31:0]   interval;
  logic [KB-1:0] k_calc;
  assign kept_lim = ({27'd0, kept_r} > 32'(SAMPLES)) ? KB'(SAMPLES) : KB'(kept_r);
  assign interval = item_r.stamp - start_r[w_r];
  assign k_calc   = (hits_r[w_r] < 32'(kept_lim)) ? KB'(hits_r[w_r]) : kept_lim;

  always_comb begin
    rd_en  = 1'b0;
    rd_idx = '0;
    if (state_r == S_MED_CAND) begin
      rd_en = 1'b1; rd_idx = i_r[SB-1:0];
    end else if (state_r == S_MED_WAIT || state_r == S_MED_SCAN) begin
      rd_en = 1'b1; rd_idx = j_r[SB-1:0];
    end
    rd_addr = MB'(w_r) * MB'(SAMPLES) + MB'(rd_idx);
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= smem[rd_addr];
    if (state_r == S_EXEC && !oor_r && item_r.func == FUNC_STOP &&
        hits_r[w_r] < 32'(kept_lim))
      smem[MB'(w_r) * MB'(SAMPLES) + MB'(hits_r[w_r][SB-1:0])] <= interval;
  end

  assign div.start = (state_r == S_EXEC) && !oor_r && item_r.func == FUNC_REPORT
                     && hits_r[w_r] != 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      kept_r   <= KEPT_RESET;
      armed_r  <= '0;
      for (int w = 0; w < WATCHES; w++) begin
        start_r[w] <= '0; sum_r[w] <= '0; max_r[w] <= '0;
        min_r[w] <= MIN_RESET; hits_r[w] <= '0;
      end
    end else begin
      if (cfg_we) kept_r <= cfg_wdata;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            // the output register is empty here, so clear it for the new result
            item_r  <= in_ch.data;
            oor_r   <= 32'(in_ch.data.watch_id) >= 32'(WATCHES);
            w_r     <= WB'(in_ch.data.watch_id);
            res_r   <= '0;
            med_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (oor_r) begin
            state_r <= S_OUT;
          end else begin
            unique case (func_t'(item_r.func))
              FUNC_START: begin
                res_r.misuse <= armed_r[w_r];
                armed_r[w_r] <= 1'b1;
                start_r[w_r] <= item_r.stamp;
                state_r      <= S_OUT;
              end
              FUNC_STOP: begin
                res_r.misuse   <= !armed_r[w_r];
                res_r.interval <= interval;
                armed_r[w_r]   <= 1'b0;
                sum_r[w_r]     <= sum_r[w_r] + {32'd0, interval};
                if (max_r[w_r] < interval) max_r[w_r] <= interval;
                if (min_r[w_r] > interval) min_r[w_r] <= interval;
                if (hits_r[w_r] != SAT32) hits_r[w_r] <= hits_r[w_r] + 32'd1;
                state_r        <= S_OUT;
              end
              FUNC_CLEAR: begin
                armed_r[w_r] <= 1'b0; start_r[w_r] <= '0;
                sum_r[w_r] <= '0; hits_r[w_r] <= '0;
                state_r <= S_OUT;
              end
              default: begin
                k_r <= k_calc;
                i_r <= '0;
                state_r <= (k_calc == '0) ? S_DIV_WAIT : S_MED_CAND;
              end
            endcase
          end
        end
        S_MED_CAND: begin
          j_r <= '0; lt_r <= '0; eq_r <= '0;
          state_r <= S_MED_WAIT;
        end
        S_MED_WAIT: begin
          cand_r  <= rd_r;
          j_r     <= j_r + KB'(1);
          state_r <= S_MED_SCAN;
        end
        S_MED_SCAN: begin
          if (rd_r < cand_r) lt_r <= lt_r + KB'(1);
          if (rd_r == cand_r) eq_r <= eq_r + KB'(1);
          j_r <= j_r + KB'(1);
          if (j_r >= k_r) state_r <= S_MED_NEXT;
        end
        S_MED_NEXT: begin
          // candidate is the median when lt <= k/2 < lt+eq
          if (!found_r && lt_r <= (k_r >> 1) && (k_r >> 1) < lt_r + eq_r) begin
            med_r <= cand_r; found_r <= 1'b1;
          end
          i_r <= i_r + KB'(1);
          state_r <= (i_r + KB'(1) >= k_r) ? S_MED_LAST : S_MED_CAND;
        end
        S_MED_LAST: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!div.busy) begin
            res_r.middle <= med_r;
            res_r.mean   <= (hits_r[w_r] != 32'd0) ? div_q : 64'd0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!oor_r) begin
            res_r.shortest <= min_r[w_r];
            res_r.longest  <= max_r[w_r];
            res_r.total    <= sum_r[w_r];
            res_r.hits     <= hits_r[w_r];
          end
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The scan counts one compare per kept sample; the candidate is one of the k
  // samples read, so eq always counts the candidate itself.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == S_IDLE && !out_ch.valid))
    else $error("ready while busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !out_ch.valid)
    else $error("result before work");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("result dropped");
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    div.start |-> !div.busy)
    else $error("divider restarted");
endmodule
`default_nettype wire

// ===== tb/interval_stats_checker.sv =====
// interval_stats_checker: watches the input, result and register ports of the
// interval statistics monitor, predicts every result and compares it.
// Depends on ism_pkg and ism_if.
module interval_stats_checker import ism_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  ism_in_if               in_mon,
  ism_out_if              out_mon,
  input  logic            cfg_we,
  input  logic [KEPT_W-1:0] cfg_wdata,
  output int              errors,
  output int              outstanding
);
  localparam int WATCH_N = 8;
  localparam int SAMPLE_N = 16;

  logic              armed_q  [WATCH_N];
  logic [31:0]       start_q  [WATCH_N];
  logic [63:0]       total_q  [WATCH_N];
  logic [31:0]       long_q   [WATCH_N];
  logic [31:0]       short_q  [WATCH_N];
  logic [31:0]       hits_q   [WATCH_N];
  logic [31:0]       samples_q[WATCH_N][SAMPLE_N];
  logic [KEPT_W-1:0] kept_q;
  out_item_t         expected_results[$];

  task automatic report_error(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s is %h, want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] median_of(int w);
    logic [31:0] sorted[SAMPLE_N];
    logic [31:0] v;
    int k;
    int j;
    k = (kept_q > SAMPLE_N) ? SAMPLE_N : int'(kept_q);
    if (hits_q[w] < k) k = int'(hits_q[w]);
    if (k == 0) return '0;
    for (int i = 0; i < k; i++) sorted[i] = samples_q[w][i];
    for (int i = 1; i < k; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[k/2];
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t res;
    logic [31:0] iv;
    int w;
    int lim;
    res = '0;
    w = it.watch_id;
    lim = (kept_q > SAMPLE_N) ? SAMPLE_N : int'(kept_q);
    case (func_t'(it.func))
      FUNC_START: begin
        res.misuse = armed_q[w];
        armed_q[w] = 1'b1;
        start_q[w] = it.stamp;
      end
      FUNC_STOP: begin
        res.misuse = !armed_q[w];
        iv = it.stamp - start_q[w];
        res.interval = iv;
        armed_q[w] = 1'b0;
        total_q[w] = total_q[w] + {32'd0, iv};
        if (long_q[w] < iv) long_q[w] = iv;
        if (short_q[w] > iv) short_q[w] = iv;
        if (hits_q[w] < lim) samples_q[w][hits_q[w]] = iv;
        if (hits_q[w] != SAT32) hits_q[w]++;
      end
      FUNC_CLEAR: begin
        armed_q[w] = 1'b0;
        start_q[w] = '0;
        total_q[w] = '0;
        hits_q[w] = '0;
      end
      default: begin
        if (hits_q[w] != 0) res.mean = total_q[w] / {32'd0, hits_q[w]};
        res.middle = median_of(w);
      end
    endcase
    res.shortest = short_q[w];
    res.longest = long_q[w];
    res.total = total_q[w];
    res.hits = hits_q[w];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      for (int w = 0; w < WATCH_N; w++) begin
        armed_q[w] = 1'b0;
        start_q[w] = '0;
        total_q[w] = '0;
        long_q[w] = '0;
        short_q[w] = MIN_RESET;
        hits_q[w] = '0;
      end
      kept_q = KEPT_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we) kept_q = cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_result(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_results.size() == 0) begin
          report_error("unexpected result, misuse", got.misuse, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.misuse !== want.misuse) report_error("misuse", got.misuse, want.misuse);
          if (got.interval !== want.interval)
            report_error("interval", got.interval, want.interval);
          if (got.shortest !== want.shortest)
            report_error("shortest", got.shortest, want.shortest);
          if (got.longest !== want.longest) report_error("longest", got.longest, want.longest);
          if (got.total !== want.total) report_error("total", got.total, want.total);
          if (got.hits !== want.hits) report_error("hits", got.hits, want.hits);
          if (got.mean !== want.mean) report_error("mean", got.mean, want.mean);
          if (got.middle !== want.middle) report_error("middle", got.middle, want.middle);
        end
      end
    end
    outstanding = expected_results.size();
  end
endmodule

// ===== tb/testbench.sv =====
// testbench: clock, reset and stimulus for interval_statistics_monitor, with
// the result checker instantiated beside the block. Depends on ism_pkg,
// ism_if and interval_stats_checker.
module testbench;
  import ism_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [KEPT_W-1:0] cfg_wdata;
  int                errors;
  int                outstanding;

  // Stimulus-side shadow: which sample slots were ever written, so that a
  // report never reads a slot that was never filled.
  int          hit_cnt[8];
  logic [15:0] wrote[8];
  logic        armed_tb[8];
  logic [31:0] now_t[8];
  int          kept_tb;
  logic        tx_burst;
  logic        rx_burst;

  ism_in_if  in_ch();
  ism_out_if out_ch();

  interval_statistics_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  interval_stats_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  // Bound the run; a hang anywhere ends here.
  initial begin
    #40000000;
    $display("interval_statistics_monitor: mismatch");
    $finish;
  end

  // Result side: draw a stall before each transaction, none in burst stretches.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = rx_burst ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  // Send one transaction; downgrade an unsafe report to a clear.
  task automatic send_op(func_t f, int w, logic [31:0] s);
    int gap;
    int lim;
    int k;
    logic [16:0] need;
    lim = (kept_tb > 16) ? 16 : kept_tb;
    if (f == FUNC_REPORT) begin
      k = (hit_cnt[w] < lim) ? hit_cnt[w] : lim;
      need = (17'd1 << k) - 17'd1;
      if ((wrote[w] & need[15:0]) != need[15:0]) f = FUNC_CLEAR;
    end
    case (f)
      FUNC_START: armed_tb[w] = 1'b1;
      FUNC_STOP: begin
        armed_tb[w] = 1'b0;
        if (hit_cnt[w] < lim) wrote[w][hit_cnt[w]] = 1'b1;
        hit_cnt[w]++;
      end
      FUNC_CLEAR: begin
        armed_tb[w] = 1'b0;
        hit_cnt[w] = 0;
      end
      default: ;
    endcase
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{func: f, watch_id: w[2:0], stamp: s};
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off until every expected result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write samples_kept while the block is idle.
  task automatic set_kept(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[KEPT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    kept_tb = v;
  endtask

  // Start and stop one watch around a random interval, mostly short.
  task automatic timed_pair(int w);
    logic [31:0] d;
    d = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3000);
    send_op(FUNC_START, w, now_t[w]);
    now_t[w] = now_t[w] + d;
    send_op(FUNC_STOP, w, now_t[w]);
    now_t[w] = now_t[w] + $urandom_range(0, 500);
  endtask

  initial begin
    int kept_plan[6];
    int sent;
    int w;
    int r;
    kept_plan = '{0, 1, 31, 3, 16, 8};
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    kept_tb = KEPT_RESET;
    for (int i = 0; i < 8; i++) begin
      hit_cnt[i] = 0;
      wrote[i] = '0;
      armed_tb[i] = 1'b0;
      now_t[i] = $urandom;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, misuse both ways, wrap, empty report, clear.
    send_op(FUNC_START, 0, 32'h0);
    send_op(FUNC_STOP, 0, 32'hffff_ffff);   // longest interval, shortest kept
    send_op(FUNC_REPORT, 0, 32'h0);
    send_op(FUNC_STOP, 0, 32'd5);           // stop while idle
    send_op(FUNC_START, 1, 32'hffff_fff0);
    send_op(FUNC_START, 1, 32'hffff_ffff);  // start while armed
    send_op(FUNC_STOP, 1, 32'd3);           // stamp wraps
    send_op(FUNC_REPORT, 1, 32'hffff_ffff);
    send_op(FUNC_REPORT, 2, 32'h1234_5678); // no hits yet
    send_op(FUNC_CLEAR, 0, 32'h0);
    send_op(FUNC_REPORT, 0, 32'h0);
    send_op(FUNC_START, 7, 32'h0);
    send_op(FUNC_STOP, 7, 32'h7fff_ffff);
    send_op(FUNC_START, 7, 32'h8000_0000);
    send_op(FUNC_STOP, 7, 32'h8000_0000);   // zero interval
    send_op(FUNC_REPORT, 7, 32'h0);
    for (int i = 3; i < 7; i++) timed_pair(i);
    send_op(FUNC_REPORT, 5, 32'haaaa_5555);

    // Random phases, one per samples_kept setting.
    foreach (kept_plan[p]) begin
      set_kept(kept_plan[p]);
      sent = 0;
      while (sent < 80) begin
        if (sent % 20 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        w = $urandom_range(0, 7);
        r = $urandom_range(0, 99);
        if (r < 60) begin
          timed_pair(w);
          sent += 2;
        end else begin
          if (r < 78) send_op(FUNC_REPORT, w, $urandom);
          else if (r < 83) send_op(FUNC_CLEAR, w, $urandom);
          else send_op(func_t'($urandom_range(0, 3)), w, $urandom);
          sent++;
        end
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("interval_statistics_monitor: match");
    end else begin
      $display("interval_statistics_monitor: mismatch");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/ism_pkg.sv
rtl/core/ism_if.sv
rtl/core/ism_divider.sv
rtl/core/interval_statistics_monitor.sv
tb/interval_stats_checker.sv
tb/testbench.sv
